>>> hw/rtl/tociir_pkg.sv
// package for the third-order channel-inverse iir filter
// holds widths, register indexes, reset coefficients and shared types
// no dependencies
package tociir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int FRAC_W   = 12;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + 3;
  localparam int SHIFT_W  = ACC_W - FRAC_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A3 = 3'd4;

  localparam logic signed [COEF_W-1:0] B0_RESET = -16'sd2048;
  localparam logic signed [COEF_W-1:0] B1_RESET = 16'sd4096;
  localparam logic signed [COEF_W-1:0] A1_RESET = 16'sd11605;
  localparam logic signed [COEF_W-1:0] A2_RESET = -16'sd7509;
  localparam logic signed [COEF_W-1:0] A3_RESET = 16'sd1365;

  localparam logic signed [ACC_W-1:0]    ROUND_HALF = 35'sd2048;
  localparam logic signed [SHIFT_W-1:0]  SAT_MAX    = 23'sd32767;
  localparam logic signed [SHIFT_W-1:0]  SAT_MIN    = -23'sd32768;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] a3;
  } coef_set_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
    logic signed [SAMPLE_W-1:0] y3;
  } tap_set_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] y;
    logic                       clip;
  } mac_res_t;

endpackage

>>> hw/rtl/tociir_if.sv
// stream and configuration interfaces for the channel-inverse filter
// depends on tociir_pkg
interface tociir_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tociir_pkg::SAMPLE_W-1:0] sample_in;
  logic                                  first_sample;
  logic                                  last_sample;
  modport source (output valid, sample_in, first_sample, last_sample, input ready);
  modport sink   (input valid, sample_in, first_sample, last_sample, output ready);
endinterface

interface tociir_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tociir_pkg::SAMPLE_W-1:0] sample_out;
  logic                                  clipped;
  logic                                  last_out;
  modport source (output valid, sample_out, clipped, last_out, input ready);
  modport sink   (input valid, sample_out, clipped, last_out, output ready);
endinterface

interface tociir_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [tociir_pkg::CFG_IDX_W-1:0]       index;
  logic [tociir_pkg::COEF_W-1:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/tociir_coef_regs.sv
// coefficient register file, written through the configuration channel
// depends on tociir_pkg and tociir_if
module tociir_coef_regs (
  input  logic                  clk,
  input  logic                  rst,
  tociir_cfg_if.sink            cfg,
  output tociir_pkg::coef_set_t coefs
);

  tociir_pkg::coef_set_t regs;

  assign cfg.ready = 1'b1;
  assign coefs     = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.b0 <= tociir_pkg::B0_RESET;
      regs.b1 <= tociir_pkg::B1_RESET;
      regs.a1 <= tociir_pkg::A1_RESET;
      regs.a2 <= tociir_pkg::A2_RESET;
      regs.a3 <= tociir_pkg::A3_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        tociir_pkg::REG_B0: regs.b0 <= cfg.data;
        tociir_pkg::REG_B1: regs.b1 <= cfg.data;
        tociir_pkg::REG_A1: regs.a1 <= cfg.data;
        tociir_pkg::REG_A2: regs.a2 <= cfg.data;
        tociir_pkg::REG_A3: regs.a3 <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/tociir_mac.sv
// five-tap multiply-accumulate with rounding and saturation to 16 bits
// depends on tociir_pkg
module tociir_mac (
  input  tociir_pkg::coef_set_t coefs,
  input  tociir_pkg::tap_set_t  taps,
  output tociir_pkg::mac_res_t  res
);

  logic signed [tociir_pkg::PROD_W-1:0]  p0, p1, p2, p3, p4;
  logic signed [tociir_pkg::ACC_W-1:0]   acc;
  logic signed [tociir_pkg::ACC_W-1:0]   rnd;
  logic signed [tociir_pkg::SHIFT_W-1:0] sh;

  assign p0 = coefs.b0 * taps.x;
  assign p1 = coefs.b1 * taps.x1;
  assign p2 = coefs.a1 * taps.y1;
  assign p3 = coefs.a2 * taps.y2;
  assign p4 = coefs.a3 * taps.y3;

  assign acc = tociir_pkg::ACC_W'(p0) + tociir_pkg::ACC_W'(p1) + tociir_pkg::ACC_W'(p2)
             + tociir_pkg::ACC_W'(p3) + tociir_pkg::ACC_W'(p4);
  assign rnd = acc + tociir_pkg::ROUND_HALF;
  // floor shift keeps the top bits
  assign sh  = rnd[tociir_pkg::ACC_W-1:tociir_pkg::FRAC_W];

  always_comb begin
    if (sh > tociir_pkg::SAT_MAX) begin
      res.y    = tociir_pkg::SAT_MAX[tociir_pkg::SAMPLE_W-1:0];
      res.clip = 1'b1;
    end else if (sh < tociir_pkg::SAT_MIN) begin
      res.y    = tociir_pkg::SAT_MIN[tociir_pkg::SAMPLE_W-1:0];
      res.clip = 1'b1;
    end else begin
      res.y    = sh[tociir_pkg::SAMPLE_W-1:0];
      res.clip = 1'b0;
    end
  end

endmodule

>>> hw/rtl/third_order_iir_channel_inverse.sv
// third-order direct-form-i iir filter that undoes a known channel
// pipeline: a request is registered in s1, its result then in the out registers
// throughput: one request per cycle if not stalled; the feedback loop closes through the mac
// reset: synchronous, clears history and handshake state, coefficients return to defaults
// depends on tociir_pkg, tociir_if, tociir_coef_regs and tociir_mac
module third_order_iir_channel_inverse (
  input  logic        clk,
  input  logic        rst,
  tociir_in_if.sink   samples,
  tociir_out_if.source results,
  tociir_cfg_if.sink  cfg
);

  tociir_pkg::coef_set_t coefs;
  tociir_pkg::tap_set_t  taps;
  tociir_pkg::mac_res_t  mac_res;

  logic                                   s1_valid;
  logic signed [tociir_pkg::SAMPLE_W-1:0] s1_x;
  logic                                   s1_first;
  logic                                   s1_last;

  logic signed [tociir_pkg::SAMPLE_W-1:0] x1, y1, y2, y3;

  logic                                   out_valid;
  logic signed [tociir_pkg::SAMPLE_W-1:0] out_sample;
  logic                                   out_clip;
  logic                                   out_last;

  logic advance;
  logic take;

  tociir_coef_regs u_coef (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .coefs (coefs)
  );

  // first sample sees an all-zero history
  assign taps.x  = s1_x;
  assign taps.x1 = s1_first ? '0 : x1;
  assign taps.y1 = s1_first ? '0 : y1;
  assign taps.y2 = s1_first ? '0 : y2;
  assign taps.y3 = s1_first ? '0 : y3;

  tociir_mac u_mac (
    .coefs (coefs),
    .taps  (taps),
    .res   (mac_res)
  );

  assign advance       = s1_valid && (!out_valid || results.ready);
  assign samples.ready = !s1_valid || advance;
  assign take          = samples.valid && samples.ready;

  assign results.valid      = out_valid;
  assign results.sample_out = out_sample;
  assign results.clipped    = out_clip;
  assign results.last_out   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_x     <= samples.sample_in;
      s1_first <= samples.first_sample;
      s1_last  <= samples.last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      y1 <= '0;
      y2 <= '0;
      y3 <= '0;
    end else if (advance) begin
      x1 <= taps.x;
      y1 <= mac_res.y;
      y2 <= taps.y1;
      y3 <= taps.y2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sample <= mac_res.y;
      out_clip   <= mac_res.clip;
      out_last   <= s1_last;
    end
  end

endmodule

>>> hw/rtl/tociir_checker.sv
// port-level checker for the channel-inverse filter, bound to the top level
// depends on tociir_pkg and third_order_iir_channel_inverse
module tociir_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [tociir_pkg::SAMPLE_W-1:0] out_sample,
  input logic                                   out_clip,
  input logic                                   out_last
);

  logic [1:0] pending;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  // requests accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_take && !out_take) begin
      pending <= pending + 2'd1;
    end else if (out_take && !in_take) begin
      pending <= pending - 2'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_clip)
      && $stable(out_last))
    else $error("stalled result changed");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two requests in flight");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result without an accepted request");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd2 && out_valid && !out_ready |-> !in_ready)
    else $error("request taken with both stages full");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind third_order_iir_channel_inverse tociir_checker u_tociir_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_sample (results.sample_out),
  .out_clip   (results.clipped),
  .out_last   (results.last_out)
);
